FILE: src/bsmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsmc_pkg
// Types, codes and constants shared by the battery system mode controller.
// ----------------------------------------------------------------------------
package bsmc_pkg;

    localparam int unsigned TimeW   = 17;
    localparam int unsigned AgeW    = 16;
    localparam int unsigned ElapsW  = 10;

    localparam logic [TimeW-1:0] InitWaitMs = TimeW'(10000);
    localparam logic [TimeW-1:0] CalLimitMs = TimeW'(120000);
    localparam logic [TimeW-1:0] TimeMax    = {TimeW{1'b1}};

    typedef enum logic [5:0] {
        MODE_UNINIT   = 6'b000001,
        MODE_INIT     = 6'b000010,
        MODE_CAL      = 6'b000100,
        MODE_INACTIVE = 6'b001000,
        MODE_OPER     = 6'b010000,
        MODE_FAULT    = 6'b100000
    } t_mode;

    typedef enum logic [2:0] {
        CODE_UNINIT   = 3'd0,
        CODE_INIT     = 3'd1,
        CODE_CAL      = 3'd2,
        CODE_INACTIVE = 3'd3,
        CODE_OPER     = 3'd4,
        CODE_FAULT    = 3'd5
    } t_mode_code;

    typedef enum logic [2:0] {
        REQ_NONE     = 3'd0,
        REQ_RUN      = 3'd1,
        REQ_STOP     = 3'd2,
        REQ_CAL_LONG = 3'd3,
        REQ_CAL_SHORT = 3'd4,
        REQ_ONLINE   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        CT_OPEN       = 2'd0,
        CT_CLOSE      = 2'd1,
        CT_CALIBRATE  = 2'd2,
        CT_FORCE_OPEN = 2'd3
    } t_ct_cmd;

    typedef enum logic [1:0] {
        CAL_OFFLINE_LONG  = 2'd0,
        CAL_OFFLINE_SHORT = 2'd1,
        CAL_ONLINE        = 2'd2
    } t_cal_cmd;

    typedef enum logic [2:0] {
        CFG_BATTERY     = 3'd0,
        CFG_OUTPUT      = 3'd1,
        CFG_CONTACTOR   = 3'd2,
        CFG_CURRENT     = 3'd3,
        CFG_CELL        = 3'd4,
        CFG_TEMPERATURE = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [ElapsW-1:0] elapsed_ms;
        logic              fatal_event;
        logic              calibration_idle;
        logic [2:0]        request_code;
        logic [AgeW-1:0]   battery_age_ms;
        logic [AgeW-1:0]   output_age_ms;
        logic [AgeW-1:0]   neg_contactor_age_ms;
        logic [AgeW-1:0]   pos_contactor_age_ms;
        logic [AgeW-1:0]   current_age_ms;
        logic [AgeW-1:0]   cell_age_ms;
        logic [AgeW-1:0]   temperature_age_ms;
    } t_in_word;

    typedef struct packed {
        logic [2:0] mode;
        logic       operating_flag;
        logic       contactor_cmd_valid;
        logic [1:0] contactor_cmd;
        logic       calibration_cmd_valid;
        logic [1:0] calibration_cmd;
        logic       save_strobe;
        logic       request_taken;
    } t_out_word;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_UNINIT:   c = CODE_UNINIT;
            MODE_INIT:     c = CODE_INIT;
            MODE_CAL:      c = CODE_CAL;
            MODE_INACTIVE: c = CODE_INACTIVE;
            MODE_OPER:     c = CODE_OPER;
            default:       c = CODE_FAULT;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/battery_system_mode_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A word passes two register stages: input register, result register.
// Throughput: one word per cycle while the output side keeps taking results.
// Reset (synchronous, active low): mode uninitialized, time in mode zero,
// operating flag clear, thresholds at their defaults, both stages empty.
// ----------------------------------------------------------------------------
// battery_system_mode_controller_top
// Supervisory battery mode machine, one tick per cycle unless output stalls.
// ----------------------------------------------------------------------------
module battery_system_mode_controller_top
    import bsmc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_word,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [AgeW-1:0] i_cfg_data
);

    logic [AgeW-1:0] r_bat_stale, r_out_stale, r_ct_stale;
    logic [AgeW-1:0] r_cur_stale, r_cell_stale, r_temp_stale;

    t_mode            r_mode, n_mode;
    logic [TimeW-1:0] r_time, n_time;
    logic             r_oper, n_oper;

    logic             r_in_valid;
    t_in_word         r_in;
    logic             r_out_valid;
    t_out_word        r_out, n_out;

    logic             advance;
    logic [TimeW:0]   time_sum;
    logic [TimeW-1:0] time_sat;
    logic             fresh;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bat_stale  <= AgeW'(1000);
            r_out_stale  <= AgeW'(1000);
            r_ct_stale   <= AgeW'(1000);
            r_cur_stale  <= AgeW'(1000);
            r_cell_stale <= AgeW'(5000);
            r_temp_stale <= AgeW'(5000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BATTERY:     r_bat_stale  <= i_cfg_data;
                CFG_OUTPUT:      r_out_stale  <= i_cfg_data;
                CFG_CONTACTOR:   r_ct_stale   <= i_cfg_data;
                CFG_CURRENT:     r_cur_stale  <= i_cfg_data;
                CFG_CELL:        r_cell_stale <= i_cfg_data;
                CFG_TEMPERATURE: r_temp_stale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    assign time_sum = {1'b0, r_time} + (TimeW+1)'(r_in.elapsed_ms);
    assign time_sat = time_sum[TimeW] ? TimeMax : time_sum[TimeW-1:0];

    assign fresh = (r_in.battery_age_ms       <= r_bat_stale)
                && (r_in.output_age_ms        <= r_out_stale)
                && (r_in.neg_contactor_age_ms <= r_ct_stale)
                && (r_in.pos_contactor_age_ms <= r_ct_stale)
                && (r_in.current_age_ms       <= r_cur_stale)
                && (r_in.cell_age_ms          <= r_cell_stale)
                && (r_in.temperature_age_ms   <= r_temp_stale);

    // one tick of the mode machine
    always_comb begin
        n_mode = r_mode;
        n_time = time_sat;
        n_oper = r_oper;
        n_out  = '0;
        if (r_in.fatal_event && r_mode != MODE_FAULT) begin
            n_oper              = 1'b0;
            n_out.save_strobe   = 1'b1;
            n_mode              = MODE_FAULT;
            n_out.contactor_cmd_valid = 1'b1;
            n_out.contactor_cmd       = CT_FORCE_OPEN;
        end else begin
            case (r_mode)
                MODE_UNINIT: begin
                    n_mode = MODE_INIT;
                end
                MODE_INIT: begin
                    if (time_sat >= InitWaitMs) begin
                        n_mode = fresh ? MODE_INACTIVE : MODE_FAULT;
                    end
                end
                MODE_CAL: begin
                    if (r_in.calibration_idle) begin
                        n_out.contactor_cmd_valid = 1'b1;
                        n_out.contactor_cmd       = CT_OPEN;
                        n_mode = MODE_INACTIVE;
                    end else if (time_sat >= CalLimitMs) begin
                        n_mode = MODE_FAULT;
                    end
                end
                MODE_INACTIVE: begin
                    case (r_in.request_code)
                        REQ_RUN: begin
                            n_out.request_taken = 1'b1;
                            n_oper              = 1'b1;
                            n_out.save_strobe   = 1'b1;
                            n_mode              = MODE_OPER;
                        end
                        REQ_CAL_LONG: begin
                            n_out.request_taken         = 1'b1;
                            n_out.contactor_cmd_valid   = 1'b1;
                            n_out.contactor_cmd         = CT_CALIBRATE;
                            n_out.calibration_cmd_valid = 1'b1;
                            n_out.calibration_cmd       = CAL_OFFLINE_LONG;
                            n_mode                      = MODE_CAL;
                        end
                        REQ_CAL_SHORT: begin
                            n_out.request_taken         = 1'b1;
                            n_out.calibration_cmd_valid = 1'b1;
                            n_out.calibration_cmd       = CAL_OFFLINE_SHORT;
                            n_mode                      = MODE_CAL;
                        end
                        REQ_ONLINE: begin
                            n_out.request_taken         = 1'b1;
                            n_out.calibration_cmd_valid = 1'b1;
                            n_out.calibration_cmd       = CAL_ONLINE;
                        end
                        default: ;
                    endcase
                end
                MODE_OPER: begin
                    n_out.contactor_cmd_valid = 1'b1;
                    n_out.contactor_cmd       = CT_CLOSE;
                    case (r_in.request_code)
                        REQ_STOP: begin
                            n_out.request_taken = 1'b1;
                            n_out.contactor_cmd = CT_OPEN;
                            n_oper              = 1'b0;
                            n_out.save_strobe   = 1'b1;
                            n_mode              = MODE_INACTIVE;
                        end
                        REQ_ONLINE: begin
                            n_out.request_taken         = 1'b1;
                            n_out.calibration_cmd_valid = 1'b1;
                            n_out.calibration_cmd       = CAL_ONLINE;
                        end
                        default: ;
                    endcase
                end
                default: begin
                    n_out.contactor_cmd_valid = 1'b1;
                    n_out.contactor_cmd       = CT_FORCE_OPEN;
                end
            endcase
        end
        if (n_mode != r_mode) begin
            n_time = '0;
        end
        n_out.mode           = mode_code(n_mode);
        n_out.operating_flag = n_oper;
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_UNINIT;
            r_time      <= '0;
            r_oper      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mode <= n_mode;
                r_time <= n_time;
                r_oper <= n_oper;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_oper_only_when_operating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.operating_flag |-> o_out_word.mode == CODE_OPER)
        else $error("operating flag set outside operating mode");

    a_save_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.save_strobe |->
            o_out_word.mode == CODE_OPER || o_out_word.mode == CODE_INACTIVE
            || o_out_word.mode == CODE_FAULT)
        else $error("save strobe on an unexpected mode change");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled while output side is free");

endmodule
`default_nettype wire

FILE: sim/bsmc_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmc_tick_checker
// Watches the tick, result and threshold channels of the mode controller.
// Keeps its own copy of the mode, the time in mode, the operating flag and
// the freshness limits. From these it works out the result word of every
// accepted tick word and checks the result words in order, field by field.
// ----------------------------------------------------------------------------
module bsmc_tick_checker
    import bsmc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  t_in_word        i_in_word,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  t_out_word       i_out_word,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [AgeW-1:0] i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);

    t_mode_code       mode_q;
    logic [TimeW-1:0] ms_in_mode;
    logic             oper_q;
    logic [AgeW-1:0]  limit_ms [6];
    t_out_word        due_q [$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void enter_mode(input t_mode_code m);
        mode_q     = m;
        ms_in_mode = '0;
    endfunction

    function automatic logic readings_ok(input t_in_word w);
        return w.battery_age_ms       <= limit_ms[CFG_BATTERY]
            && w.output_age_ms        <= limit_ms[CFG_OUTPUT]
            && w.neg_contactor_age_ms <= limit_ms[CFG_CONTACTOR]
            && w.pos_contactor_age_ms <= limit_ms[CFG_CONTACTOR]
            && w.current_age_ms       <= limit_ms[CFG_CURRENT]
            && w.cell_age_ms          <= limit_ms[CFG_CELL]
            && w.temperature_age_ms   <= limit_ms[CFG_TEMPERATURE];
    endfunction

    function automatic t_out_word tick_result(input t_in_word w);
        t_out_word      r;
        logic [TimeW:0] sum;
        r   = '0;
        sum = ms_in_mode + w.elapsed_ms;
        ms_in_mode = (sum > {1'b0, TimeMax}) ? TimeMax : sum[TimeW-1:0];

        if (mode_q != CODE_FAULT && w.fatal_event) begin
            oper_q        = 1'b0;
            r.save_strobe = 1'b1;
            enter_mode(CODE_FAULT);
        end

        case (mode_q)
            CODE_UNINIT: begin
                enter_mode(CODE_INIT);
            end
            CODE_INIT: begin
                if (ms_in_mode >= InitWaitMs) begin
                    enter_mode(readings_ok(w) ? CODE_INACTIVE : CODE_FAULT);
                end
            end
            CODE_CAL: begin
                if (w.calibration_idle) begin
                    r.contactor_cmd_valid = 1'b1;
                    r.contactor_cmd       = CT_OPEN;
                    enter_mode(CODE_INACTIVE);
                end else if (ms_in_mode >= CalLimitMs) begin
                    enter_mode(CODE_FAULT);
                end
            end
            CODE_INACTIVE: begin
                case (w.request_code)
                    REQ_RUN: begin
                        r.request_taken = 1'b1;
                        r.save_strobe   = 1'b1;
                        oper_q          = 1'b1;
                        enter_mode(CODE_OPER);
                    end
                    REQ_CAL_LONG: begin
                        r.request_taken         = 1'b1;
                        r.contactor_cmd_valid   = 1'b1;
                        r.contactor_cmd         = CT_CALIBRATE;
                        r.calibration_cmd_valid = 1'b1;
                        r.calibration_cmd       = CAL_OFFLINE_LONG;
                        enter_mode(CODE_CAL);
                    end
                    REQ_CAL_SHORT: begin
                        r.request_taken         = 1'b1;
                        r.calibration_cmd_valid = 1'b1;
                        r.calibration_cmd       = CAL_OFFLINE_SHORT;
                        enter_mode(CODE_CAL);
                    end
                    REQ_ONLINE: begin
                        r.request_taken         = 1'b1;
                        r.calibration_cmd_valid = 1'b1;
                        r.calibration_cmd       = CAL_ONLINE;
                    end
                    default: begin
                    end
                endcase
            end
            CODE_OPER: begin
                r.contactor_cmd_valid = 1'b1;
                r.contactor_cmd       = CT_CLOSE;
                if (w.request_code == REQ_STOP) begin
                    r.request_taken = 1'b1;
                    r.contactor_cmd = CT_OPEN;
                    r.save_strobe   = 1'b1;
                    oper_q          = 1'b0;
                    enter_mode(CODE_INACTIVE);
                end else if (w.request_code == REQ_ONLINE) begin
                    r.request_taken         = 1'b1;
                    r.calibration_cmd_valid = 1'b1;
                    r.calibration_cmd       = CAL_ONLINE;
                end
            end
            default: begin
                r.contactor_cmd_valid = 1'b1;
                r.contactor_cmd       = CT_FORCE_OPEN;
            end
        endcase

        r.mode           = mode_q;
        r.operating_flag = oper_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            mode_q     = CODE_UNINIT;
            ms_in_mode = '0;
            oper_q     = 1'b0;
            limit_ms[CFG_BATTERY]     = AgeW'(1000);
            limit_ms[CFG_OUTPUT]      = AgeW'(1000);
            limit_ms[CFG_CONTACTOR]   = AgeW'(1000);
            limit_ms[CFG_CURRENT]     = AgeW'(1000);
            limit_ms[CFG_CELL]        = AgeW'(5000);
            limit_ms[CFG_TEMPERATURE] = AgeW'(5000);
            due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= CFG_TEMPERATURE) begin
                limit_ms[i_cfg_index] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (due_q.size() == 0) begin
                    $display("%0t: result word with no tick pending, expected none, got %h",
                             $time, i_out_word);
                    mismatches++;
                end else begin
                    want = due_q.pop_front();
                    check_field("mode", want.mode, i_out_word.mode);
                    check_field("operating_flag", want.operating_flag,
                                i_out_word.operating_flag);
                    check_field("contactor_cmd_valid", want.contactor_cmd_valid,
                                i_out_word.contactor_cmd_valid);
                    check_field("contactor_cmd", want.contactor_cmd,
                                i_out_word.contactor_cmd);
                    check_field("calibration_cmd_valid", want.calibration_cmd_valid,
                                i_out_word.calibration_cmd_valid);
                    check_field("calibration_cmd", want.calibration_cmd,
                                i_out_word.calibration_cmd);
                    check_field("save_strobe", want.save_strobe, i_out_word.save_strobe);
                    check_field("request_taken", want.request_taken,
                                i_out_word.request_taken);
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_q.push_back(tick_result(i_in_word));
            end
        end
        o_pending <= due_q.size();
    end

endmodule

FILE: sim/battery_system_mode_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_system_mode_controller_top_test
// Drives tick words and threshold writes into the mode controller. A short
// directed pass takes the block through initialization and every request,
// then random phases under several threshold settings, with random gaps on
// both sides, a long output stall and a drain before each phase. The run
// ends in fault, by a fatal event or a calibration timeout.
// ----------------------------------------------------------------------------
module battery_system_mode_controller_top_test;
    import bsmc_pkg::*;

    localparam int unsigned    CycleLimit  = 200000;
    localparam int unsigned    HoldCycles  = 300;
    localparam int unsigned    SafeCalMs   = 100000;
    localparam logic [2:0]     ReqSpare6   = 3'd6;
    localparam logic [2:0]     ReqSpare7   = 3'd7;
    localparam logic [ElapsW-1:0] MaxElapsed = '1;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            tick_valid  = 1'b0;
    logic            tick_ready;
    t_in_word        tick_word   = '0;
    logic            res_valid;
    logic            res_ready   = 1'b0;
    t_out_word       res_word;
    logic            cfg_valid   = 1'b0;
    logic            cfg_ready;
    logic [2:0]      cfg_index   = '0;
    logic [AgeW-1:0] cfg_data    = '0;

    logic            calm        = 1'b0;
    logic            rx_hold     = 1'b0;
    event            rx_hold_kick;
    int              fail_count;
    int              pending;
    int unsigned     cycle_count = 0;
    int unsigned     ms_since_idle = 0;
    logic [AgeW-1:0] thr_set [6];

    always #10 clk = ~clk;

    battery_system_mode_controller_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (tick_ready),
        .i_in_word   (tick_word),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_word  (res_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bsmc_tick_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (tick_valid),
        .i_in_ready   (tick_ready),
        .i_in_word    (tick_word),
        .i_out_valid  (res_valid),
        .i_out_ready  (res_ready),
        .i_out_word   (res_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("battery_system_mode_controller_top verification failed");
            $finish;
        end
    end

    // result side
    always @(posedge clk) begin
        if (!rst_n || rx_hold) begin
            res_ready <= 1'b0;
        end else begin
            res_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always begin
        @(rx_hold_kick);
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_tick(input t_in_word w);
        tick_valid <= 1'b1;
        tick_word  <= w;
        do @(posedge clk); while (!tick_ready);
        if (!calm && $urandom_range(99) < 7) begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        tick_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_limits(input int setting);
        t_cfg_index idx;
        case (setting)
            0: begin
                thr_set[CFG_BATTERY]     = '0;
                thr_set[CFG_OUTPUT]      = '1;
                thr_set[CFG_CONTACTOR]   = AgeW'(1234);
                thr_set[CFG_CURRENT]     = AgeW'(1);
                thr_set[CFG_CELL]        = AgeW'(65534);
                thr_set[CFG_TEMPERATURE] = AgeW'(5000);
            end
            1: foreach (thr_set[i]) thr_set[i] = '0;
            2: foreach (thr_set[i]) thr_set[i] = '1;
            4: begin
                thr_set[CFG_BATTERY]     = AgeW'(1000);
                thr_set[CFG_OUTPUT]      = AgeW'(1000);
                thr_set[CFG_CONTACTOR]   = AgeW'(1000);
                thr_set[CFG_CURRENT]     = AgeW'(1000);
                thr_set[CFG_CELL]        = AgeW'(5000);
                thr_set[CFG_TEMPERATURE] = AgeW'(5000);
            end
            default: foreach (thr_set[i]) thr_set[i] = AgeW'($urandom_range(65535));
        endcase
        idx = CFG_BATTERY;
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= thr_set[idx];
            do @(posedge clk); while (!cfg_ready);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    // readings either all at the maximum age or each exactly at its limit
    function automatic t_in_word tick_of(input logic [ElapsW-1:0] el, input logic idle,
                                         input logic [2:0] req, input logic stale);
        t_in_word w;
        w.elapsed_ms           = el;
        w.fatal_event          = 1'b0;
        w.calibration_idle     = idle;
        w.request_code         = req;
        w.battery_age_ms       = stale ? '1 : thr_set[CFG_BATTERY];
        w.output_age_ms        = stale ? '1 : thr_set[CFG_OUTPUT];
        w.neg_contactor_age_ms = stale ? '1 : thr_set[CFG_CONTACTOR];
        w.pos_contactor_age_ms = stale ? '1 : thr_set[CFG_CONTACTOR];
        w.current_age_ms       = stale ? '1 : thr_set[CFG_CURRENT];
        w.cell_age_ms          = stale ? '1 : thr_set[CFG_CELL];
        w.temperature_age_ms   = stale ? '1 : thr_set[CFG_TEMPERATURE];
        return w;
    endfunction

    function automatic logic [AgeW-1:0] age_ms();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return AgeW'($urandom_range(65535));
        endcase
    endfunction

    // quiet words keep inactive and operating in place
    task automatic send_random(input logic quiet, input logic at_end);
        t_in_word   w;
        logic [2:0] keep_reqs [4];
        keep_reqs = '{REQ_NONE, REQ_ONLINE, ReqSpare6, ReqSpare7};
        w.elapsed_ms = at_end ? ElapsW'($urandom_range(1023, 700))
                              : ElapsW'($urandom_range(1023));
        w.fatal_event      = at_end ? 1'($urandom_range(1)) : 1'b0;
        w.calibration_idle = ($urandom_range(3) == 0) || (ms_since_idle > SafeCalMs);
        if (quiet) begin
            w.request_code = keep_reqs[$urandom_range(3)];
        end else begin
            w.request_code = ($urandom_range(2) == 0) ? REQ_NONE : 3'($urandom_range(7));
        end
        w.battery_age_ms       = age_ms();
        w.output_age_ms        = age_ms();
        w.neg_contactor_age_ms = age_ms();
        w.pos_contactor_age_ms = age_ms();
        w.current_age_ms       = age_ms();
        w.cell_age_ms          = age_ms();
        w.temperature_age_ms   = age_ms();
        ms_since_idle = w.calibration_idle ? 0 : ms_since_idle + w.elapsed_ms;
        send_tick(w);
    endtask

    initial begin
        t_in_word w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_limits(0);

        // uninitialized, then initializing with stale readings until the deadline
        send_tick(tick_of('0, 1'b1, REQ_RUN, 1'b1));
        repeat (9) send_tick(tick_of(MaxElapsed, 1'b0, REQ_CAL_LONG, 1'b1));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_NONE, 1'b0));
        // inactive
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_STOP, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, ReqSpare7, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_ONLINE, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_CAL_SHORT, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_NONE, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b1, REQ_NONE, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_CAL_LONG, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b1, REQ_NONE, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_RUN, 1'b0));
        // operating
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_NONE, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_CAL_LONG, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_ONLINE, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, ReqSpare6, 1'b0));
        send_tick(tick_of(MaxElapsed, 1'b0, REQ_STOP, 1'b0));

        for (int phase = 1; phase <= 5; phase++) begin
            drain();
            set_limits(phase);
            calm <= (phase == 2);
            if (phase == 4) begin
                -> rx_hold_kick;
            end
            for (int n = 0; n < 300; n++) begin
                send_random(phase == 3 && n < 140, 1'b0);
            end
        end

        drain();
        if ($urandom_range(1) == 0) begin
            // calibration that never reports idle
            send_tick(tick_of(MaxElapsed, 1'b1, REQ_STOP, 1'b0));
            send_tick(tick_of(MaxElapsed, 1'b0, REQ_CAL_SHORT, 1'b0));
            repeat (120) send_tick(tick_of(MaxElapsed, 1'b0, REQ_NONE, 1'b0));
        end else begin
            w = tick_of(ElapsW'($urandom_range(1023)), 1'($urandom_range(1)),
                        3'($urandom_range(7)), 1'($urandom_range(1)));
            w.fatal_event = 1'b1;
            send_tick(w);
        end
        repeat (150) send_random(1'b0, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("battery_system_mode_controller_top verification clean");
        end else begin
            $display("battery_system_mode_controller_top verification failed");
        end
        $finish;
    end

endmodule
